### design/q2r_pkg.sv
package q2r_pkg;

  localparam int DATA_WIDTH = 16;
  // remainder width: n needs 2*DATA_WIDTH+1 bits, doubled remainder one more
  localparam int RW = 2 * DATA_WIDTH + 2;
  localparam int LANES = 9;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m13;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] m23;
    logic signed [DATA_WIDTH-1:0] m31;
    logic signed [DATA_WIDTH-1:0] m32;
    logic signed [DATA_WIDTH-1:0] m33;
    logic                         degenerate;
  } matrix_t;

  // one numerator: sign and magnitude
  typedef struct packed {
    logic          neg;
    logic [RW-1:0] mag;
  } lane_t;

endpackage

### design/quaternion_to_rotation_matrix_core.sv
// channel   signals                 handshake
// input     start, busy, quat       item taken when start && !busy
// result    done, result            item shown for one cycle while done
//
// one item per cycle, every cycle; busy is always low
// stages: input, products, sums, divider load, one stage per quotient bit but the last
// of the nine parallel restoring dividers, then last bit, round and output
// synchronous reset clears the valid bits only; items in flight are dropped
// the receiver cannot stall, so results simply stream out behind done
module quaternion_to_rotation_matrix_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  q2r_pkg::quat_t    quat,
  output logic              done,
  output q2r_pkg::matrix_t  result
);
  import q2r_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;

  function automatic lane_t off_num(input logic signed [RW-1:0] a,
                                    input logic signed [RW-1:0] b);
    logic signed [RW-1:0] d;
    lane_t r;
    d = a - b;
    r.neg = d[RW-1];
    r.mag = d[RW-1] ? (RW'(0) - d) : d;
    r.mag = {r.mag[RW-2:0], 1'b0};
    return r;
  endfunction

  function automatic lane_t diag_num(input logic [RW-1:0] p, input logic [RW-1:0] q);
    lane_t r;
    r.neg = (p < q);
    r.mag = r.neg ? (q - p) : (p - q);
    return r;
  endfunction

  assign busy = 1'b0;

  // input stage
  logic  va;
  quat_t qa;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start;
    end
    qa <= quat;
  end

  // product stage
  logic                 vb;
  logic signed [PW-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    ww <= qa.quat_w * qa.quat_w;
    xx <= qa.quat_x * qa.quat_x;
    yy <= qa.quat_y * qa.quat_y;
    zz <= qa.quat_z * qa.quat_z;
    wx <= qa.quat_w * qa.quat_x;
    wy <= qa.quat_w * qa.quat_y;
    wz <= qa.quat_w * qa.quat_z;
    xy <= qa.quat_x * qa.quat_y;
    xz <= qa.quat_x * qa.quat_z;
    yz <= qa.quat_y * qa.quat_z;
  end

  // sum stage: norm and the nine numerators
  logic          vc;
  logic          dc;
  logic [RW-1:0] nc;
  lane_t         numc [LANES];

  logic [RW-1:0]        uww, uxx, uyy, uzz, n_next;
  logic signed [RW-1:0] swx, swy, swz, sxy, sxz, syz;

  always_comb begin
    uww = RW'($unsigned(ww));
    uxx = RW'($unsigned(xx));
    uyy = RW'($unsigned(yy));
    uzz = RW'($unsigned(zz));
    swx = RW'(wx);
    swy = RW'(wy);
    swz = RW'(wz);
    sxy = RW'(xy);
    sxz = RW'(xz);
    syz = RW'(yz);
    n_next = uww + uxx + uyy + uzz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    dc <= (n_next == '0);
    nc <= n_next;
    numc[0] <= diag_num(uww + uxx, uyy + uzz);
    numc[1] <= off_num(sxy, swz);
    numc[2] <= off_num(sxz, -swy);
    numc[3] <= off_num(sxy, -swz);
    numc[4] <= diag_num(uww + uyy, uxx + uzz);
    numc[5] <= off_num(syz, swx);
    numc[6] <= off_num(sxz, swy);
    numc[7] <= off_num(syz, -swx);
    numc[8] <= diag_num(uww + uzz, uxx + uyy);
  end

  q2r_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vc),
    .in_degen  (dc),
    .in_n      (nc),
    .in_num    (numc),
    .out_valid (done),
    .out_mat   (result)
  );

endmodule

### design/q2r_div_pipe.sv
module q2r_div_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_degen,
  input  logic [q2r_pkg::RW-1:0] in_n,
  input  q2r_pkg::lane_t       in_num [q2r_pkg::LANES],
  output logic                 out_valid,
  output q2r_pkg::matrix_t     out_mat
);
  import q2r_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int ST = DW - 1;

  logic          v     [ST];
  logic          dg    [ST];
  logic [RW-1:0] nn    [ST];
  logic          neg   [ST][LANES];
  logic [RW-1:0] rem   [ST][LANES];
  logic [DW-2:0] quo   [ST][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    dg[0] <= in_degen;
    nn[0] <= in_n;
    for (int l = 0; l < LANES; l++) begin
      neg[0][l] <= in_num[l].neg;
      rem[0][l] <= in_num[l].mag;
      quo[0][l] <= '0;
    end
  end

  // one quotient bit per stage; first stage gives the integer bit
  genvar s;
  for (s = 0; s < ST - 1; s++) begin : g_step
    logic [RW-1:0] rem_next [LANES];
    logic [DW-2:0] quo_next [LANES];

    always_comb begin
      logic [RW-1:0] t;
      logic          b;
      for (int l = 0; l < LANES; l++) begin
        t = (s == 0) ? rem[s][l] : {rem[s][l][RW-2:0], 1'b0};
        b = (t >= nn[s]);
        rem_next[l] = b ? (t - nn[s]) : t;
        quo_next[l] = {quo[s][l][DW-3:0], b};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      dg[s+1] <= dg[s];
      nn[s+1] <= nn[s];
      for (int l = 0; l < LANES; l++) begin
        neg[s+1][l] <= neg[s][l];
        rem[s+1][l] <= rem_next[l];
        quo[s+1][l] <= quo_next[l];
      end
    end
  end

  // last fraction bit, rounding, sign and identity for a zero norm
  logic [DW-1:0] elem [LANES];

  always_comb begin
    logic [RW-1:0] t;
    logic          b;
    logic [RW-1:0] r2;
    logic          rnd;
    logic [DW-2:0] q;
    logic [DW-2:0] mag;
    for (int l = 0; l < LANES; l++) begin
      t   = {rem[ST-1][l][RW-2:0], 1'b0};
      b   = (t >= nn[ST-1]);
      r2  = b ? (t - nn[ST-1]) : t;
      q   = {quo[ST-1][l][DW-3:0], b};
      rnd = ({r2[RW-2:0], 1'b0} >= nn[ST-1]);
      // below one lsb stays exact zero
      mag = q + {{(DW-2){1'b0}}, (q != '0) && rnd};
      if (dg[ST-1]) begin
        elem[l] = (l % 4 == 0) ? (DW'(1) << (DW - 2)) : '0;
      end else begin
        elem[l] = neg[ST-1][l] ? (DW'(0) - {1'b0, mag}) : {1'b0, mag};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[ST-1];
    end
    out_mat.m11        <= elem[0];
    out_mat.m12        <= elem[1];
    out_mat.m13        <= elem[2];
    out_mat.m21        <= elem[3];
    out_mat.m22        <= elem[4];
    out_mat.m23        <= elem[5];
    out_mat.m31        <= elem[6];
    out_mat.m32        <= elem[7];
    out_mat.m33        <= elem[8];
    out_mat.degenerate <= dg[ST-1];
  end

endmodule

### bench/tb_quaternion_to_rotation_matrix_core.sv
module tb_quaternion_to_rotation_matrix_core;
  import q2r_pkg::*;

  localparam int LATENCY = DATA_WIDTH + 3;
  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1 << (DATA_WIDTH - 2));

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  quat_t   quat;
  logic    done;
  matrix_t result;

  quaternion_to_rotation_matrix_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat(quat), .done(done), .result(result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_t pending_matrices[$];
  int      mismatch_count = 0;
  int      sender_idle_pct = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // rounded, clamped ratio (neg, mag << dbl) / n in output format
  function automatic logic signed [DATA_WIDTH-1:0] scaled_ratio(
      input bit neg, input logic [63:0] mag, input int dbl, input logic [64:0] norm);
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [127:0] lim;
    num = {64'd0, mag} << (dbl + DATA_WIDTH - 2);
    if (num < {63'd0, norm}) return '0;
    quo = num / {63'd0, norm};
    rem = num % {63'd0, norm};
    if ((rem << 1) >= {63'd0, norm}) quo++;
    lim = 128'd1 << (DATA_WIDTH - 1);
    if (!neg) lim = lim - 1;
    if (quo > lim) quo = lim;
    if (neg) quo = -quo;
    return quo[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] off_elem(
      input longint a, input longint b, input logic [64:0] norm);
    if (a >= b) return scaled_ratio(1'b0, a - b, 1, norm);
    return scaled_ratio(1'b1, b - a, 1, norm);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] diag_elem(
      input longint p, input longint q, input logic [64:0] norm);
    if (p >= q) return scaled_ratio(1'b0, p - q, 0, norm);
    return scaled_ratio(1'b1, q - p, 0, norm);
  endfunction

  function automatic matrix_t rotation_of(input quat_t q);
    longint w, x, y, z, ww, xx, yy, zz;
    logic [64:0] norm;
    matrix_t m;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    norm = 65'(ww + xx + yy + zz);
    m = '0;
    if (norm == 0) begin
      m.m11 = ONE; m.m22 = ONE; m.m33 = ONE;
      m.degenerate = 1'b1;
      return m;
    end
    m.m11 = diag_elem(ww + xx, yy + zz, norm);
    m.m12 = off_elem(x * y, w * z, norm);
    m.m13 = off_elem(x * z, -(w * y), norm);
    m.m21 = off_elem(x * y, -(w * z), norm);
    m.m22 = diag_elem(ww + yy, xx + zz, norm);
    m.m23 = off_elem(y * z, w * x, norm);
    m.m31 = off_elem(x * z, w * y, norm);
    m.m32 = off_elem(y * z, -(w * x), norm);
    m.m33 = diag_elem(ww + zz, xx + yy, norm);
    return m;
  endfunction

  // compare each strobed matrix against the oldest prediction
  always @(posedge clk) begin
    matrix_t want;
    if (!rst && done) begin
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected matrix", 1, 0);
      end else begin
        want = pending_matrices.pop_front();
        if (result.m11 !== want.m11) report_mismatch("m11", result.m11, want.m11);
        if (result.m12 !== want.m12) report_mismatch("m12", result.m12, want.m12);
        if (result.m13 !== want.m13) report_mismatch("m13", result.m13, want.m13);
        if (result.m21 !== want.m21) report_mismatch("m21", result.m21, want.m21);
        if (result.m22 !== want.m22) report_mismatch("m22", result.m22, want.m22);
        if (result.m23 !== want.m23) report_mismatch("m23", result.m23, want.m23);
        if (result.m31 !== want.m31) report_mismatch("m31", result.m31, want.m31);
        if (result.m32 !== want.m32) report_mismatch("m32", result.m32, want.m32);
        if (result.m33 !== want.m33) report_mismatch("m33", result.m33, want.m33);
        if (result.degenerate !== want.degenerate)
          report_mismatch("degenerate", result.degenerate, want.degenerate);
      end
    end
  end

  // start stays high across back-to-back items; one assignment per edge
  task automatic send_quat(input quat_t q);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    quat  <= q;
    do @(posedge clk); while (busy);
    pending_matrices.push_back(rotation_of(q));
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_lane();
    case ($urandom_range(5))
      0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2: return DATA_WIDTH'($signed($urandom_range(8)) - 4);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  typedef struct {
    quat_t   q;
    bit      known;
    matrix_t want;
  } quat_row_t;

  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  quat_row_t directed_rows[$];

  initial begin
    matrix_t ident, neg_eye;
    quat_t   q;
    ident = '0; ident.m11 = ONE; ident.m22 = ONE; ident.m33 = ONE;
    neg_eye = ident; neg_eye.m22 = -ONE; neg_eye.m33 = -ONE;
    // zero quaternion gives identity and the degenerate flag
    ident.degenerate = 1'b1;
    directed_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
    ident.degenerate = 1'b0;
    directed_rows.push_back('{'{MAXV, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
    directed_rows.push_back('{'{MINV, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
    directed_rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident});
    // pure x rotation by pi
    directed_rows.push_back('{'{16'sd0, MINV, 16'sd0, 16'sd0}, 1'b1, neg_eye});
    directed_rows.push_back('{'{16'sd0, MAXV, 16'sd0, 16'sd0}, 1'b1, neg_eye});
    directed_rows.push_back('{'{16'sd0, 16'sd0, MAXV, 16'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, MINV}, 1'b0, '0});
    directed_rows.push_back('{'{MINV, MINV, MINV, MINV}, 1'b0, '0});
    directed_rows.push_back('{'{MAXV, MAXV, MAXV, MAXV}, 1'b0, '0});
    directed_rows.push_back('{'{MAXV, MINV, MAXV, MINV}, 1'b0, '0});
    directed_rows.push_back('{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{16'sd1, 16'sd1, -16'sd1, 16'sd1}, 1'b0, '0});
    // tiny component against a huge one: off-diagonals land within about one lsb of zero
    directed_rows.push_back('{'{MAXV, 16'sd1, 16'sd0, 16'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{MINV, 16'sd0, -16'sd1, 16'sd1}, 1'b0, '0});
    directed_rows.push_back('{'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0}, 1'b0, '0});
    directed_rows.push_back('{'{16'sd0, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0});
    directed_rows.push_back('{'{16'sd3, 16'sd0, 16'sd4, 16'sd0}, 1'b0, '0});

    rst = 1'b1;
    start = 1'b0;
    quat = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_quat(directed_rows[i].q);
      if (directed_rows[i].known && rotation_of(directed_rows[i].q) !== directed_rows[i].want)
        report_mismatch("directed row", i, i);
    end

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 27 : 0;
      for (int i = 0; i < 260; i++) begin
        q.quat_w = random_lane(); q.quat_x = random_lane();
        q.quat_y = random_lane(); q.quat_z = random_lane();
        send_quat(q);
      end
      if (phase == 1) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
design/q2r_pkg.sv
design/q2r_div_pipe.sv
design/quaternion_to_rotation_matrix_core.sv
bench/tb_quaternion_to_rotation_matrix_core.sv
